// File: sv/plid_pkg.sv
// ----------------------------------------------------------------------------
// plid_pkg
// Types and codes shared by the positional list controller, datapath and top.
// ----------------------------------------------------------------------------
package plid_pkg;

  localparam int ValueW = 32;
  localparam int PosW   = 8;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_LIST   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ValueW-1:0] element;
    logic [4:0]               count;
    logic                     last;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic req_load;
    logic op_exec;
    logic list_emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic list_go;
    logic list_last;
  } dp_stat_t;

endpackage

// File: sv/positional_list_insert_delete_top.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top
// Ordered list of signed 32-bit values with insert and delete by one-based
// position and an in-order listing.
//
//   channel | ports                        | carries
//   --------+------------------------------+-------------------------------
//   in      | in_valid, in_stall, in_data  | cmd, value, position
//   out     | out_valid, out_stall, out_data | status, element, count, last
//
// Insert and delete: capture, then a parallel shift of the cell row with the
// result registered; unused commands and errors register a result only.
// List: one element per cycle off the head of the rotating cell row, while
// the output is not stalled. A new request is taken while the last result still
// waits. Synchronous reset empties the list; no clearing pass is needed.
// A stalled output holds the sequencer until the slot frees.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_top #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  plid_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output plid_pkg::out_item_t out_data
);

  plid_pkg::dp_cmd_t  dp_cmd;
  plid_pkg::dp_stat_t dp_stat;

  plid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  plid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (dp_cmd),
    .stat     (dp_stat),
    .out_data (out_data)
  );

  a_busy_after_request : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while previous one in progress");

  a_error_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != plid_pkg::ST_OK)) |-> out_data.last)
    else $error("error result not marked last");

  a_list_holds_input : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> in_stall)
    else $error("request accepted mid listing");

  a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == plid_pkg::ST_FULL)) |->
      (out_data.count == 5'(CAPACITY)))
    else $error("full reported below capacity");

endmodule

// File: sv/plid_ctrl.sv
// ----------------------------------------------------------------------------
// plid_ctrl
// Sequencer for the positional list: takes a request, runs it, then streams
// list results one per free output slot.
// ----------------------------------------------------------------------------
module plid_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  plid_pkg::dp_stat_t stat,
  output plid_pkg::dp_cmd_t  cmd
);

  plid_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plid_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      plid_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = plid_pkg::S_EXEC;
        end
      end
      plid_pkg::S_EXEC: begin
        if (stat.list_go) begin
          state_nxt = plid_pkg::S_LIST;
        end else if (slot_free) begin
          cmd.op_exec = 1'b1;
          state_nxt   = plid_pkg::S_IDLE;
        end
      end
      plid_pkg::S_LIST: begin
        if (slot_free) begin
          cmd.list_emit = 1'b1;
          if (stat.list_last) begin
            state_nxt = plid_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = plid_pkg::S_IDLE;
      end
    endcase

    if (cmd.op_exec || cmd.list_emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: sv/plid_dp.sv
// ----------------------------------------------------------------------------
// plid_dp
// Row of list cells with parallel shift for insert and delete, rotation for
// listing, element count, request register and output register.
// ----------------------------------------------------------------------------
module plid_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  plid_pkg::in_item_t  in_data,
  input  plid_pkg::dp_cmd_t   cmd,
  output plid_pkg::dp_stat_t  stat,
  output plid_pkg::out_item_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = plid_pkg::ValueW;
  localparam int PW = plid_pkg::PosW;

  logic [CAPACITY-1:0][VW-1:0] cells_r, cells_nxt, left_v, right_v;
  plid_pkg::in_item_t          req_r;
  plid_pkg::out_item_t         out_r, out_nxt;
  logic [CW-1:0]               count_r, count_nxt, idx_r, idx_nxt;
  logic [CW-1:0]               at_ins, at_del;
  logic [PW-1:0]               count_ext;
  logic                        full, pos_in, do_ins, do_del, do_rot;

  assign count_ext = PW'(count_r);
  assign full      = (count_r == CW'(CAPACITY));
  assign pos_in    = (req_r.position != '0) && (req_r.position <= count_ext);
  assign at_del    = CW'(req_r.position - PW'(1));
  assign at_ins    = pos_in ? at_del : count_r;

  assign do_ins = cmd.op_exec && (req_r.cmd == plid_pkg::CMD_INSERT) && !full;
  assign do_del = cmd.op_exec && (req_r.cmd == plid_pkg::CMD_DELETE) &&
                  (count_r != '0) && pos_in;
  assign do_rot = cmd.list_emit;

  // neighbour views: left_v[i] is cell i+1, right_v[i] is cell i-1
  assign left_v  = cells_r >> VW;
  assign right_v = cells_r << VW;

  always_comb begin
    cells_nxt = cells_r;
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_ins) begin
        if (CW'(i) == at_ins) begin
          cells_nxt[i] = req_r.value;
        end else if ((CW'(i) > at_ins) && (CW'(i) <= count_r)) begin
          cells_nxt[i] = right_v[i];
        end
      end else if (do_del) begin
        if ((CW'(i) >= at_del) && ((CW'(i) + CW'(1)) < count_r)) begin
          cells_nxt[i] = left_v[i];
        end
      end else if (do_rot) begin
        if (CW'(i) < count_r) begin
          cells_nxt[i] = ((CW'(i) + CW'(1)) == count_r) ? cells_r[0] : left_v[i];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (do_del) begin
      count_nxt = count_r - CW'(1);
    end

    idx_nxt = idx_r;
    if (cmd.req_load) begin
      idx_nxt = '0;
    end else if (cmd.list_emit) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  assign stat.list_go   = (req_r.cmd == plid_pkg::CMD_LIST) && (count_r != '0);
  assign stat.list_last = ((idx_r + CW'(1)) == count_r);

  always_comb begin
    out_nxt         = out_r;
    out_nxt.element = '0;
    out_nxt.count   = 5'(count_nxt);
    out_nxt.last    = 1'b1;
    out_nxt.status  = plid_pkg::ST_OK;
    if (cmd.list_emit) begin
      out_nxt.element = cells_r[0];
      out_nxt.last    = stat.list_last;
    end else begin
      case (req_r.cmd)
        plid_pkg::CMD_INSERT: begin
          if (full) begin
            out_nxt.status = plid_pkg::ST_FULL;
          end
        end
        plid_pkg::CMD_DELETE: begin
          if (count_r == '0) begin
            out_nxt.status = plid_pkg::ST_EMPTY;
          end else if (!pos_in) begin
            out_nxt.status = plid_pkg::ST_RANGE;
          end
        end
        plid_pkg::CMD_LIST: begin
          out_nxt.status = plid_pkg::ST_EMPTY;
        end
        default: begin
          out_nxt.status = plid_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cells_r <= cells_nxt;
    if (cmd.req_load) begin
      req_r <= in_data;
    end
    if (cmd.op_exec || cmd.list_emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule
